[rtl/rsas_pkg.sv]
// ----------------------------------------------------------------------------
// rsas_pkg: shared types and microprogram for the rotated array search
// Holds the field widths, request kinds, the control word format and the
// read-only microprogram that sequences one search request.
// ----------------------------------------------------------------------------
`default_nettype none

package rsas_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned KIND_W = 2;
  localparam int unsigned POS_W  = 10;
  localparam int unsigned STEP_W = 4;

  typedef logic [KIND_W-1:0] kind_t;
  typedef logic [STEP_W-1:0] step_t;

  localparam kind_t KIND_CLEAR  = 2'd0;
  localparam kind_t KIND_APPEND = 2'd1;
  localparam kind_t KIND_SEARCH = 2'd2;

  // Datapath operation selected by the current control word.
  typedef enum logic [3:0] {
    OP_IDLE,
    OP_PINIT,
    OP_FIRST,
    OP_PPROBE,
    OP_PCMP,
    OP_PEND,
    OP_PIV,
    OP_CHOOSE,
    OP_BPROBE,
    OP_BCMP,
    OP_NOTFOUND,
    OP_EMIT
  } op_t;

  // Branch condition tested at the end of a step.
  typedef enum logic [2:0] {
    C_ALWAYS,
    C_SEARCH,
    C_EMPTY,
    C_LO_LT_HI,
    C_LO_LE_HI,
    C_HIT,
    C_OUT_FREE
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target_true;
    step_t target_false;
  } ctl_word_t;

  localparam step_t STEP_IDLE     = 4'd0;
  localparam step_t STEP_PINIT    = 4'd1;
  localparam step_t STEP_FIRST    = 4'd2;
  localparam step_t STEP_PPROBE   = 4'd3;
  localparam step_t STEP_PCMP     = 4'd4;
  localparam step_t STEP_PEND     = 4'd5;
  localparam step_t STEP_PIV      = 4'd6;
  localparam step_t STEP_CHOOSE   = 4'd7;
  localparam step_t STEP_BPROBE   = 4'd8;
  localparam step_t STEP_BCMP     = 4'd9;
  localparam step_t STEP_NOTFOUND = 4'd10;
  localparam step_t STEP_EMIT     = 4'd11;

  // The microprogram. Unused step codes park the sequencer back in idle.
  function automatic ctl_word_t ucode(input step_t step);
    ctl_word_t w;
    unique case (step)
      STEP_IDLE:     w = '{OP_IDLE,     C_SEARCH,   STEP_PINIT,  STEP_IDLE};
      STEP_PINIT:    w = '{OP_PINIT,    C_EMPTY,    STEP_NOTFOUND, STEP_FIRST};
      STEP_FIRST:    w = '{OP_FIRST,    C_ALWAYS,   STEP_PPROBE, STEP_PPROBE};
      STEP_PPROBE:   w = '{OP_PPROBE,   C_LO_LT_HI, STEP_PCMP,   STEP_PEND};
      STEP_PCMP:     w = '{OP_PCMP,     C_ALWAYS,   STEP_PPROBE, STEP_PPROBE};
      STEP_PEND:     w = '{OP_PEND,     C_ALWAYS,   STEP_PIV,    STEP_PIV};
      STEP_PIV:      w = '{OP_PIV,      C_ALWAYS,   STEP_CHOOSE, STEP_CHOOSE};
      STEP_CHOOSE:   w = '{OP_CHOOSE,   C_ALWAYS,   STEP_BPROBE, STEP_BPROBE};
      STEP_BPROBE:   w = '{OP_BPROBE,   C_LO_LE_HI, STEP_BCMP,   STEP_NOTFOUND};
      STEP_BCMP:     w = '{OP_BCMP,     C_HIT,      STEP_EMIT,   STEP_BPROBE};
      STEP_NOTFOUND: w = '{OP_NOTFOUND, C_ALWAYS,   STEP_EMIT,   STEP_EMIT};
      STEP_EMIT:     w = '{OP_EMIT,     C_OUT_FREE, STEP_IDLE,   STEP_EMIT};
      default:       w = '{OP_IDLE,     C_ALWAYS,   STEP_IDLE,   STEP_IDLE};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

[rtl/rotated_sorted_array_search.sv]
// ----------------------------------------------------------------------------
// rotated_sorted_array_search: key lookup in a rotated ascending array
// Stores appended signed words and answers search requests with a pivot
// search followed by a binary search, run by a small microcoded sequencer.
// ----------------------------------------------------------------------------
// Usage. The input channel (in_valid/in_ready, in_kind, in_value) carries
// three kinds of request: clear empties the array, append stores in_value at
// the next free index (ignored when the array is full), and search looks up
// in_value. Only a search produces a response on the output channel
// (out_valid/out_ready, out_found, out_position); out_position is the index
// of the key when found and zero otherwise. Unused kind codes are dropped.
// Clear and append requests complete in the cycle they are accepted. A search
// occupies the sequencer: seven fixed steps (two before the pivot search,
// three between the two searches, a not-found step on a miss and the output
// step), a probe step and a compare step for every memory probe because the
// array read is registered, and a final probe step that ends each loop. Over
// 1024 entries the pivot search makes ten probes and the range search at
// most ten. The sequencer is back in idle, ready for the next request, in the
// same cycle that the response becomes valid. The finished response sits
// in an output register; the sequencer returns to idle and accepts new
// requests while that response waits, and only stalls in its final step if
// a second response is ready before the first was taken.
// Reset empties the array and drops any pending response; array contents
// are not cleared, since only entries below the element count are read.
// ----------------------------------------------------------------------------
`default_nettype none

module rotated_sorted_array_search #(
  parameter int unsigned MAX_ELEMENTS = 1024
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [rsas_pkg::KIND_W-1:0]         in_kind,
  input  wire logic signed [rsas_pkg::DATA_W-1:0]  in_value,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic                                     out_found,
  output logic [rsas_pkg::POS_W-1:0]               out_position
);

  import rsas_pkg::*;

  // Address width of the element memory, count width able to hold the
  // capacity itself, and a signed index width one bit wider so that an
  // upper bound of minus one is representable.
  localparam int unsigned AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int unsigned CW = $clog2(MAX_ELEMENTS + 1);
  localparam int unsigned SW = CW + 1;

  // Sequencer state.
  step_t     step_r;
  step_t     step_nxt;
  ctl_word_t ctl;
  logic      cond_true;

  // Array state.
  logic signed [DATA_W-1:0] mem [MAX_ELEMENTS];
  logic [CW-1:0]            count_r;
  logic signed [DATA_W-1:0] rd_data_r;
  logic [AW-1:0]            rd_addr;
  logic                     mem_we;

  // Search datapath registers.
  logic signed [DATA_W-1:0] key_r;
  logic signed [DATA_W-1:0] first_r;
  logic signed [DATA_W-1:0] pivot_val_r;
  logic signed [SW-1:0]     lo_r;
  logic signed [SW-1:0]     hi_r;
  logic signed [SW-1:0]     mid_r;
  logic signed [SW-1:0]     pivot_r;
  logic                     res_found_r;
  logic [POS_W-1:0]         res_pos_r;

  // Output register.
  logic                     out_valid_r;
  logic                     out_found_r;
  logic [POS_W-1:0]         out_position_r;

  logic signed [SW-1:0]     last_idx;
  logic signed [SW-1:0]     span;
  logic signed [SW-1:0]     mid_calc;
  logic                     in_acc;
  logic                     out_free;
  logic                     array_full;
  logic                     key_in_upper;

  assign ctl          = ucode(step_r);
  assign in_ready     = (ctl.op == OP_IDLE);
  assign in_acc       = in_valid && in_ready;
  assign out_free     = !out_valid_r || out_ready;
  assign array_full   = (count_r == CW'(MAX_ELEMENTS));
  assign mem_we       = in_acc && (in_kind == KIND_APPEND) && !array_full;

  // Index arithmetic: last valid index, midpoint of the current window.
  assign last_idx     = $signed({1'b0, count_r}) - SW'(1);
  assign span         = hi_r - lo_r;
  assign mid_calc     = lo_r + (span >>> 1);
  // The key lies in the sorted run that starts at the pivot.
  assign key_in_upper = (key_r >= pivot_val_r) && (key_r <= rd_data_r);

  // Branch condition of the current control word.
  always_comb begin
    unique case (ctl.cond)
      C_ALWAYS:   cond_true = 1'b1;
      C_SEARCH:   cond_true = in_acc && (in_kind == KIND_SEARCH);
      C_EMPTY:    cond_true = (count_r == '0);
      C_LO_LT_HI: cond_true = (lo_r < hi_r);
      C_LO_LE_HI: cond_true = (lo_r <= hi_r);
      C_HIT:      cond_true = (rd_data_r == key_r);
      C_OUT_FREE: cond_true = out_free;
      default:    cond_true = 1'b1;
    endcase
    step_nxt = cond_true ? ctl.target_true : ctl.target_false;
  end

  // Memory read address for the step being executed.
  always_comb begin
    unique case (ctl.op)
      OP_PPROBE, OP_BPROBE: rd_addr = mid_calc[AW-1:0];
      OP_PEND:              rd_addr = lo_r[AW-1:0];
      OP_PIV:               rd_addr = last_idx[AW-1:0];
      default:              rd_addr = '0;
    endcase
  end

  // Element memory: one write port for appends, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[count_r[AW-1:0]] <= in_value;
    end
    rd_data_r <= mem[rd_addr];
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= STEP_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      step_r <= step_nxt;
      if (in_acc && (in_kind == KIND_CLEAR)) begin
        count_r <= '0;
      end else if (mem_we) begin
        count_r <= count_r + CW'(1);
      end
      if ((ctl.op == OP_EMIT) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Search datapath, one operation per microprogram step.
  always_ff @(posedge clk) begin
    unique case (ctl.op)
      OP_IDLE: begin
        if (in_acc) begin
          key_r <= in_value;
        end
      end
      OP_PINIT: begin
        lo_r        <= '0;
        hi_r        <= last_idx;
        res_found_r <= 1'b0;
        res_pos_r   <= '0;
      end
      OP_FIRST: begin
        first_r <= rd_data_r;
      end
      OP_PPROBE, OP_BPROBE: begin
        mid_r <= mid_calc;
      end
      OP_PCMP: begin
        // Entries not below the first element belong to the left run.
        if (rd_data_r >= first_r) begin
          lo_r <= mid_r + SW'(1);
        end else begin
          hi_r <= mid_r;
        end
      end
      OP_PEND: begin
        pivot_r <= lo_r;
      end
      OP_PIV: begin
        pivot_val_r <= rd_data_r;
      end
      OP_CHOOSE: begin
        if (key_in_upper) begin
          lo_r <= pivot_r;
          hi_r <= last_idx;
        end else begin
          lo_r <= '0;
          hi_r <= pivot_r - SW'(1);
        end
      end
      OP_BCMP: begin
        if (rd_data_r == key_r) begin
          res_found_r <= 1'b1;
          res_pos_r   <= POS_W'(mid_r);
        end else if (key_r > rd_data_r) begin
          lo_r <= mid_r + SW'(1);
        end else begin
          hi_r <= mid_r - SW'(1);
        end
      end
      OP_NOTFOUND: begin
        res_found_r <= 1'b0;
        res_pos_r   <= '0;
      end
      OP_EMIT: begin
        if (out_free) begin
          out_found_r    <= res_found_r;
          out_position_r <= res_pos_r;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid    = out_valid_r;
  assign out_found    = out_found_r;
  assign out_position = out_position_r;

endmodule

`default_nettype wire

[test/rotated_sorted_array_search_tb.sv]
// ----------------------------------------------------------------------------
// rotated_sorted_array_search_tb: self-checking bench for the rotated search
// Streams clear, append and search requests into the block under several
// traffic mixes and checks every response against an in-bench predictor.
// ----------------------------------------------------------------------------

module rotated_sorted_array_search_tb;

  import rsas_pkg::*;

  localparam int CLK_PERIOD     = 20;
  localparam int MAX_ELEMENTS   = 1024;
  localparam int ARR_AW         = $clog2(MAX_ELEMENTS);
  localparam int RX_HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES  = 60;
  // Far beyond the slowest legal run, including the full-array phase.
  localparam int WATCHDOG_CYCLES = 400_000;
  localparam int REPORT_LIMIT    = 100;

  // Kind code that the block must drop without a response.
  localparam kind_t KIND_UNUSED = 2'd3;

  // Index sentinel for a key that the range search did not locate.
  localparam int NOT_FOUND = -1;

  localparam logic signed [DATA_W-1:0] WORD_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;

  // Bounds for building ascending value ramps in 64-bit arithmetic.
  localparam longint RAMP_FLOOR = -64'sd2147483648;
  localparam longint RAMP_SPAN  = 64'sh0000_0000_FFFF_FFFF;

  typedef struct {
    kind_t                     kind;
    logic signed [DATA_W-1:0]  value;
  } request_t;

  typedef struct packed {
    logic              found;
    logic [POS_W-1:0]  position;
  } answer_t;

  // Well-formed sets are rotated ascending runs; the other two shapes feed the
  // search steps data that breaks their assumptions.
  typedef enum {SET_ROTATED, SET_UNSORTED, SET_REPEATS} set_shape_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  kind_t                      in_kind = KIND_CLEAR;
  logic signed [DATA_W-1:0]   in_value = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic                       out_found;
  logic [POS_W-1:0]           out_position;

  rotated_sorted_array_search #(
    .MAX_ELEMENTS(MAX_ELEMENTS)
  ) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_kind      (in_kind),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_found    (out_found),
    .out_position (out_position)
  );

  // --------------------------------------------------------------------------
  // Bench state.
  // --------------------------------------------------------------------------

  // Requests waiting to be offered, and responses the predictor has promised
  // but the block has not yet delivered.
  request_t pending_requests[$];
  answer_t  expected_answers[$];

  // The predictor's own copy of the array and its element count.
  logic signed [DATA_W-1:0] arr_words [MAX_ELEMENTS];
  logic [10:0]              arr_count = '0;

  // Traffic shaping, changed by the stimulus only between phases.
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;

  // Long receiver hold-off: the stimulus raises hold_go, the hold process
  // counts the cycles and raises hold_over when it is done.
  logic hold_go = 1'b0;
  logic hold_over = 1'b0;
  wire  rx_holding = hold_go && !hold_over;

  int       error_count = 0;
  int       queued_items = 0;
  request_t next_req;

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Predictor.
  // --------------------------------------------------------------------------

  // Locates a key the way the block does: a pivot search that compares each
  // probe against the first word, then a binary search in whichever sorted
  // half can hold the key. Unsorted or repeated data goes through the very
  // same steps, so the answer is whatever those steps land on.
  function automatic answer_t lookup_key(input logic signed [DATA_W-1:0] key);
    int      n;
    int      lo;
    int      hi;
    int      mid;
    int      pivot;
    int      idx;
    answer_t ans;
    ans = '{found: 1'b0, position: '0};
    n = arr_count;
    if (n == 0) return ans;

    lo = 0;
    hi = n - 1;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (arr_words[mid] >= arr_words[0]) lo = mid + 1;
      else hi = mid;
    end
    pivot = lo;

    // The upper run is chosen only if the key lies within its end values.
    if (key >= arr_words[pivot] && key <= arr_words[n - 1]) begin
      lo = pivot;
      hi = n - 1;
    end else begin
      lo = 0;
      hi = pivot - 1;
    end

    idx = NOT_FOUND;
    while (lo <= hi && idx == NOT_FOUND) begin
      mid = lo + (hi - lo) / 2;
      if (arr_words[mid] == key) idx = mid;
      else if (key > arr_words[mid]) lo = mid + 1;
      else hi = mid - 1;
    end

    if (idx != NOT_FOUND) begin
      ans.found = 1'b1;
      ans.position = idx[POS_W-1:0];
    end
    return ans;
  endfunction

  // Applies one accepted request to the predicted array. Only a search
  // leaves an answer behind; an append to a full array is dropped.
  function automatic void absorb_request(input kind_t k, input logic signed [DATA_W-1:0] v);
    case (k)
      KIND_CLEAR: arr_count = '0;
      KIND_APPEND: begin
        if (arr_count < MAX_ELEMENTS) begin
          arr_words[arr_count[ARR_AW-1:0]] = v;
          arr_count = arr_count + 1'b1;
        end
      end
      KIND_SEARCH: expected_answers.push_back(lookup_key(v));
      default: ;
    endcase
  endfunction

  task automatic flag_mismatch(input string msg);
    if (error_count < REPORT_LIMIT) $display("MISMATCH at %0t: %s", $time, msg);
    error_count++;
  endtask

  // --------------------------------------------------------------------------
  // Driver. A request is handed to the predictor on the edge where it is
  // accepted, and the next one is put up only once the port is free, so
  // valid and payload stay steady while the block stalls.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) absorb_request(in_kind, in_value);
      if (!in_valid || in_ready) begin
        if (pending_requests.size() > 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
          next_req = pending_requests.pop_front();
          in_valid <= 1'b1;
          in_kind  <= next_req.kind;
          in_value <= next_req.value;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor. Every delivered response is matched against the oldest
  // outstanding answer, one field at a time. Ready is redrawn every cycle and
  // forced low for the whole of the long hold-off.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_answers.size() == 0) begin
          flag_mismatch($sformatf("response found=%0b position=%0d with no search outstanding",
                                  out_found, out_position));
        end else begin
          automatic answer_t want = expected_answers.pop_front();
          if (out_found !== want.found)
            flag_mismatch($sformatf("found is %0b, predicted %0b", out_found, want.found));
          if (out_position !== want.position)
            flag_mismatch($sformatf("position is %0d, predicted %0d",
                                    out_position, want.position));
        end
      end
      out_ready <= !rx_holding && ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  // The receiver hold-off is counted here so that the stimulus can keep
  // queueing requests while the output side is blocked.
  initial begin
    wait (hold_go);
    repeat (RX_HOLD_CYCLES) @(negedge clk);
    hold_over = 1'b1;
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers.
  // --------------------------------------------------------------------------

  task automatic add_request(input kind_t k, input logic signed [DATA_W-1:0] v);
    pending_requests.push_back('{kind: k, value: v});
    queued_items++;
  endtask

  // Waits until every queued request has gone in and every search has been
  // answered. The sender stays quiet for the whole wait.
  task automatic drain_block();
    while (pending_requests.size() != 0 || in_valid || expected_answers.size() != 0)
      @(negedge clk);
  endtask

  // Queues one data set: an optional clear, n appends, any extra appends
  // (ignored once the array is full) and a handful of searches. Keys mix
  // stored words, their neighbors, the word extremes and random words.
  task automatic add_array_set(input int n, input set_shape_t shape, input int extra);
    longint                    ramp[$];
    longint                    maxgap;
    longint                    budget;
    longint                    cur;
    longint                    tmp;
    int                        rot;
    int                        searches;
    int                        j;
    logic signed [DATA_W-1:0]  key;

    // Now and then the clear is left out, so the new words land behind the
    // old ones and the array stops being a single rotated run.
    if ($urandom_range(0, 9) != 0) add_request(KIND_CLEAR, $urandom());

    case ($urandom_range(0, 2))
      0: maxgap = 3;
      1: maxgap = 5000;
      default: maxgap = RAMP_SPAN / (n + 1);
    endcase
    if (maxgap > RAMP_SPAN / (n + 1)) maxgap = RAMP_SPAN / (n + 1);
    budget = RAMP_SPAN - maxgap * n;
    case ($urandom_range(0, 3))
      0: cur = RAMP_FLOOR;
      1: cur = RAMP_FLOOR + budget;
      default: cur = RAMP_FLOOR + (longint'($urandom) % (budget + 1));
    endcase

    for (int i = 0; i < n; i++) begin
      ramp.push_back(cur);
      if (shape == SET_REPEATS) cur += $urandom_range(0, int'(maxgap));
      else cur += $urandom_range(1, int'(maxgap));
    end
    if (shape == SET_UNSORTED) begin
      for (int i = 0; i < n; i++) begin
        j = $urandom_range(0, n - 1);
        tmp = ramp[i];
        ramp[i] = ramp[j];
        ramp[j] = tmp;
      end
    end

    rot = (n > 0) ? $urandom_range(0, n - 1) : 0;
    for (int i = 0; i < n; i++) add_request(KIND_APPEND, 32'(ramp[(i + rot) % n]));
    for (int i = 0; i < extra; i++) add_request(KIND_APPEND, $urandom());
    if ($urandom_range(0, 9) == 0) add_request(KIND_UNUSED, $urandom());

    searches = (n > 100) ? 24 : $urandom_range(1, 6);
    for (int s = 0; s < searches; s++) begin
      j = (n > 0) ? $urandom_range(0, n - 1) : 0;
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: key = (n > 0) ? 32'(ramp[j]) : $urandom();
        5: key = (n > 0) ? 32'(ramp[j] + 1) : WORD_MAX;
        6: key = (n > 0) ? 32'(ramp[j] - 1) : WORD_MIN;
        7: key = $urandom_range(0, 1) ? WORD_MIN : WORD_MAX;
        default: key = $urandom();
      endcase
      add_request(KIND_SEARCH, key);
    end
  endtask

  // Queues random sets until the phase has about the given number of items.
  // Most sets are small and well formed; a few are empty, large or broken.
  task automatic run_random_sets(input int goal);
    int         first;
    int         pick;
    int         n;
    set_shape_t shape;
    first = queued_items;
    while (queued_items - first < goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) n = 0;
      else if (pick < 80) n = $urandom_range(1, 16);
      else if (pick < 95) n = $urandom_range(17, 64);
      else n = $urandom_range(65, 200);
      pick = $urandom_range(0, 99);
      if (pick < 80) shape = SET_ROTATED;
      else if (pick < 90) shape = SET_UNSORTED;
      else shape = SET_REPEATS;
      add_array_set(n, shape, 0);
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus. Reset once, then four phases with different traffic mixes.
  // Every phase boundary is a full drain, which doubles as the sender's
  // pause until all answers are back.
  // --------------------------------------------------------------------------
  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Phase one: no idling on either side. The directed requests come
    // first: a search of an empty array, a dropped kind, the word extremes
    // in an unrotated array, a search right after a clear, a rotated array
    // with keys on both runs, and a single-element array.
    add_request(KIND_SEARCH, 32'sd0);
    add_request(KIND_UNUSED, 32'shFFFF_FFFF);
    add_request(KIND_APPEND, WORD_MIN);
    add_request(KIND_APPEND, -32'sd1);
    add_request(KIND_APPEND, 32'sd0);
    add_request(KIND_APPEND, WORD_MAX);
    add_request(KIND_SEARCH, WORD_MIN);
    add_request(KIND_SEARCH, WORD_MAX);
    add_request(KIND_SEARCH, -32'sd1);
    add_request(KIND_SEARCH, 32'sd1);
    add_request(KIND_CLEAR, 32'sh5555_AAAA);
    add_request(KIND_SEARCH, 32'sd5);
    add_request(KIND_APPEND, 32'sd7);
    add_request(KIND_APPEND, 32'sd9);
    add_request(KIND_APPEND, -32'sd5);
    add_request(KIND_APPEND, -32'sd2);
    add_request(KIND_SEARCH, -32'sd5);
    add_request(KIND_SEARCH, 32'sd9);
    add_request(KIND_SEARCH, 32'sd8);
    add_request(KIND_SEARCH, WORD_MIN);
    add_request(KIND_CLEAR, 32'sh0);
    add_request(KIND_APPEND, 32'sd42);
    add_request(KIND_SEARCH, 32'sd42);
    add_request(KIND_SEARCH, 32'sd41);
    add_request(KIND_UNUSED, 32'sh0);
    run_random_sets(100);
    drain_block();

    // Phase two: sender idles about half the time. One set fills the array
    // to capacity, pushes a few appends past the end, and searches it.
    tx_idle_pct = 51;
    add_array_set(MAX_ELEMENTS, SET_ROTATED, 4);
    run_random_sets(40);
    drain_block();

    // Phase three: receiver stalls about half the time, and starts with a
    // long hold-off while requests keep coming, so the finished responses
    // back up and the block has to hold off its input.
    tx_idle_pct = 0;
    rx_stall_pct = 51;
    hold_go = 1'b1;
    run_random_sets(100);
    drain_block();

    // Phase four: both sides idle at random.
    tx_idle_pct = 38;
    rx_stall_pct = 38;
    run_random_sets(100);
    drain_block();

    // A last quiet stretch catches any response the block was not asked for.
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    #(CLK_PERIOD * WATCHDOG_CYCLES);
    $display("timeout with %0d answers outstanding", expected_answers.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
